// ===== hdl/orsq_pkg.sv =====
// package for the 1-wire search-rom sequencer
// types, codes, constants and the direction-suggest function; no dependencies
package orsq_pkg;

    localparam int ROM_BYTES_DEF = 8;
    localparam int FORK_W        = 7;
    localparam int POS_W         = 6;
    localparam int ADDR_W        = 64;
    localparam int CRC_W         = 8;

    localparam logic [FORK_W-1:0] NO_FORK  = 7'h7F;
    localparam logic [CRC_W-1:0]  CRC_POLY = 8'h8C;

    typedef enum logic [1:0] {
        REQ_FIRST   = 2'd0,
        REQ_NEXT    = 2'd1,
        REQ_TRIPLET = 2'd2,
        REQ_BAD     = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_BIT_REQ  = 3'd0,
        ST_FOUND    = 3'd1,
        ST_CRC_RTRY = 3'd2,
        ST_DONE     = 3'd3,
        ST_NO_PRES  = 3'd4,
        ST_BUS_ERR  = 3'd5,
        ST_CRC_FAIL = 3'd6,
        ST_SEQ_ERR  = 3'd7
    } t_status;

    typedef struct packed {
        logic              presence;
        logic              single_bit;
        logic              complement_bit;
        logic              taken_direction;
        t_req              req_type;
    } t_request;

    typedef struct packed {
        logic [ADDR_W-1:0] rom_bits;
        logic [FORK_W-1:0] last_fork;
        logic [FORK_W-1:0] restore_fork;
        logic [FORK_W-1:0] newest_zero_fork;
        logic              final_device;
        logic [POS_W-1:0]  bit_counter;
        logic              search_active;
        logic [CRC_W-1:0]  crc_running;
    } t_state;

    typedef struct packed {
        t_status           status;
        logic              next_direction;
        logic [POS_W-1:0]  bit_position;
        logic [ADDR_W-1:0] device_address;
    } t_result;

    function automatic logic suggest(input logic [ADDR_W-1:0] rom,
                                     input logic [FORK_W-1:0] fork_at,
                                     input logic [POS_W-1:0]  idx);
        logic [FORK_W-1:0] wide_idx;
        wide_idx = {1'b0, idx};
        if (fork_at != NO_FORK && wide_idx < fork_at) begin
            return rom[idx];
        end
        return (fork_at == wide_idx);
    endfunction

endpackage

// ===== hdl/orsq_step.sv =====
// one search step: next state and result for one registered request
// depends on orsq_pkg
module orsq_step #(
    parameter int ROM_BYTES = orsq_pkg::ROM_BYTES_DEF
) (
    input  orsq_pkg::t_state   i_state,
    input  orsq_pkg::t_request i_req,
    output orsq_pkg::t_state   o_state,
    output orsq_pkg::t_result  o_result
);
    import orsq_pkg::*;

    localparam int CRC_BITS = (ROM_BYTES - 1) * 8;
    localparam logic [FORK_W-1:0] LAST_IDX  = FORK_W'(ROM_BYTES * 8 - 1);
    localparam logic [FORK_W-1:0] CRC_LIMIT = FORK_W'(CRC_BITS);

    logic [FORK_W-1:0] bit_idx;
    logic [CRC_W-1:0]  crc_byte;
    logic              mix;

    assign bit_idx = {1'b0, i_state.bit_counter};

    always_comb begin
        o_state  = i_state;
        o_result = '{status: ST_SEQ_ERR, next_direction: 1'b0,
                     bit_position: '0, device_address: '0};
        mix      = 1'b0;
        crc_byte = '0;
        case (i_req.req_type)
            REQ_FIRST, REQ_NEXT: begin
                o_state.search_active = 1'b0;
                if (i_req.req_type == REQ_FIRST) begin
                    o_state.rom_bits     = '0;
                    o_state.last_fork    = NO_FORK;
                    o_state.final_device = 1'b0;
                    o_state.restore_fork = NO_FORK;
                end else if (!i_state.final_device) begin
                    o_state.restore_fork = i_state.last_fork;
                end
                if (i_req.req_type == REQ_NEXT && i_state.final_device) begin
                    o_result.status = ST_DONE;
                end else if (!i_req.presence) begin
                    o_result.status = ST_NO_PRES;
                end else begin
                    o_state.search_active    = 1'b1;
                    o_state.bit_counter      = '0;
                    o_state.newest_zero_fork = NO_FORK;
                    o_state.crc_running      = '0;
                    o_result.status          = ST_BIT_REQ;
                    o_result.next_direction  =
                        suggest(o_state.rom_bits, o_state.last_fork, '0);
                end
            end
            REQ_TRIPLET: begin
                if (i_state.search_active) begin
                    if (i_req.single_bit && i_req.complement_bit) begin
                        o_state.search_active = 1'b0;
                        o_result.status       = ST_BUS_ERR;
                    end else begin
                        if (!i_req.single_bit && !i_req.complement_bit &&
                            !i_req.taken_direction) begin
                            o_state.newest_zero_fork = bit_idx;
                        end
                        o_state.rom_bits[i_state.bit_counter] = i_req.taken_direction;
                        if (bit_idx < CRC_LIMIT) begin
                            mix = i_state.crc_running[0] ^ i_req.taken_direction;
                            o_state.crc_running = (i_state.crc_running >> 1) ^
                                                  (mix ? CRC_POLY : '0);
                        end
                        if (bit_idx != LAST_IDX) begin
                            o_state.bit_counter     = i_state.bit_counter + 1'b1;
                            o_result.status         = ST_BIT_REQ;
                            o_result.bit_position   = o_state.bit_counter;
                            o_result.next_direction = suggest(o_state.rom_bits,
                                i_state.last_fork, o_state.bit_counter);
                        end else begin
                            o_state.search_active = 1'b0;
                            o_state.bit_counter   = '0;
                            o_state.last_fork     = o_state.newest_zero_fork;
                            o_state.final_device  = (o_state.newest_zero_fork == NO_FORK);
                            crc_byte = o_state.rom_bits[CRC_BITS +: CRC_W];
                            if (crc_byte == '0) begin
                                o_result.status = ST_DONE;
                            end else if (o_state.crc_running == crc_byte) begin
                                o_result.status         = ST_FOUND;
                                o_result.device_address = o_state.rom_bits;
                            end else if (o_state.newest_zero_fork ==
                                         i_state.restore_fork) begin
                                o_result.status = ST_CRC_FAIL;
                            end else begin
                                o_state.last_fork = i_state.restore_fork;
                                o_result.status   = ST_CRC_RTRY;
                            end
                        end
                    end
                end
            end
            default: begin
                o_result.status = ST_SEQ_ERR;
            end
        endcase
    end

endmodule

// ===== hdl/onewire_rom_search_sequencer.sv =====
// top level of the 1-wire search-rom sequencer: input register, search state,
// result register; depends on orsq_pkg and orsq_step
//
//   channel   dir  tdata (low bit up)                         tuser
//   s_axis    in   presence, single_bit, complement_bit,      req_type
//                  taken_direction, 4 pad zeros
//   m_axis    out  next_direction, bit_position,              status
//                  device_address, 1 pad zero
//
// one beat per cycle sustained while the result side is ready; a taken beat passes
// through the input register, then step logic into the result register
// synchronous active-low reset clears the search state and both valid flags
// a stalled result holds; the input register takes one more beat if it is empty
module onewire_rom_search_sequencer #(
    parameter int ROM_BYTES = orsq_pkg::ROM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // presence, single_bit, complement_bit, taken_direction
    input  logic [1:0]  i_s_axis_tuser,   // req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // next_direction, bit_position, device_address
    output logic [2:0]  o_m_axis_tuser    // status
);
    import orsq_pkg::*;

    logic     r_in_valid;
    t_request r_in;
    t_state   r_state;
    t_state   n_state;
    t_result  n_result;
    logic     r_out_valid;
    t_result  r_out;
    logic     advance;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    orsq_step #(.ROM_BYTES(ROM_BYTES)) u_step (
        .i_state  (r_state),
        .i_req    (r_in),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.req_type        <= t_req'(i_s_axis_tuser);
            r_in.presence        <= i_s_axis_tdata[0];
            r_in.single_bit      <= i_s_axis_tdata[1];
            r_in.complement_bit  <= i_s_axis_tdata[2];
            r_in.taken_direction <= i_s_axis_tdata[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{rom_bits: '0, last_fork: NO_FORK, restore_fork: NO_FORK,
                         newest_zero_fork: NO_FORK, final_device: 1'b0,
                         bit_counter: '0, search_active: 1'b0, crc_running: '0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {1'b0, r_out.device_address, r_out.bit_position,
                              r_out.next_direction};

endmodule

// ===== hdl/orsq_checker.sv =====
// port-level checks for the 1-wire search-rom sequencer, bound to the top level
// depends on orsq_pkg and onewire_rom_search_sequencer
module orsq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [71:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser
);
    import orsq_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_dir_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_BIT_REQ |-> o_m_axis_tdata[6:0] == '0)
        else $error("direction or position set on an outcome");

    a_addr_found_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != ST_FOUND |-> o_m_axis_tdata[71:7] == '0)
        else $error("address shown without a found outcome");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind onewire_rom_search_sequencer orsq_checker u_orsq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
